### rtl/srfm_pkg.sv
// ----------------------------------------------------------------------------
// srfm_pkg
// Shared types and constants for the streaming first-match replace block.
// ----------------------------------------------------------------------------
package srfm_pkg;

   // fixed field widths
   localparam int BYTE_W = 8;
   localparam int REG_W  = 64;
   localparam int LEN_W  = 4;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_PATTERN_BYTES  = 2'd0,
      CSR_PATTERN_LENGTH = 2'd1,
      CSR_REPLACE_BYTES  = 2'd2,
      CSR_REPLACE_LENGTH = 2'd3
   } csr_addr_type;

   // control shared by every window cell
   typedef struct packed {
      logic             update;
      logic             shift;
      logic [LEN_W-1:0] count;
      logic [LEN_W-1:0] plen;
   } win_ctrl_type;

   // one output word held in the output row
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } out_word_type;

   // control for one output cell
   typedef struct packed {
      logic shift;
      logic load;
   } q_ctrl_type;

endpackage

### rtl/srfm_win_cell.sv
// ----------------------------------------------------------------------------
// srfm_win_cell
// One byte of the match window: takes the new byte at the fill position,
// compares against its pattern byte and shifts towards the oldest end.
// ----------------------------------------------------------------------------
module srfm_win_cell #(
   parameter int CELL_IDX = 0
) (
   input  logic                          clock,
   input  srfm_pkg::win_ctrl_type        ctrl,
   input  logic [srfm_pkg::BYTE_W-1:0]   in_byte,
   input  logic [srfm_pkg::BYTE_W-1:0]   nbr_cand,
   input  logic [srfm_pkg::BYTE_W-1:0]   pat_byte,
   output logic [srfm_pkg::BYTE_W-1:0]   cand,
   output logic                          hit
);
   import srfm_pkg::*;

   logic [BYTE_W-1:0] win_ff;
   logic [BYTE_W-1:0] win_in;

   // take the new byte where the window is being filled
   assign cand = (ctrl.count == LEN_W'(CELL_IDX)) ? in_byte : win_ff;

   // positions past the pattern length always agree
   assign hit = (LEN_W'(CELL_IDX) >= ctrl.plen) || (cand == pat_byte);

   // advance towards the oldest end on a mismatch of a full window
   assign win_in = ctrl.shift ? nbr_cand : cand;

   always_ff @(posedge clock) begin
      if (ctrl.update) begin
         win_ff <= win_in;
      end
   end

endmodule

### rtl/srfm_out_cell.sv
// ----------------------------------------------------------------------------
// srfm_out_cell
// One slot of the output row: loads a result word, or moves its neighbour's
// word one place towards the output when the head word is taken.
// ----------------------------------------------------------------------------
module srfm_out_cell (
   input  logic                   clock,
   input  srfm_pkg::q_ctrl_type   ctrl,
   input  srfm_pkg::out_word_type nbr_word,
   input  srfm_pkg::out_word_type load_word,
   output srfm_pkg::out_word_type word
);
   import srfm_pkg::*;

   out_word_type word_ff;
   out_word_type word_in;

   // load wins over the shift, otherwise hold
   always_comb begin
      priority if (ctrl.load) begin
         word_in = load_word;
      end else if (ctrl.shift) begin
         word_in = nbr_word;
      end else begin
         word_in = word_ff;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

### rtl/stream_replace_first_match.sv
// ----------------------------------------------------------------------------
// stream_replace_first_match
// Copies a line byte by byte, replacing the first occurrence of a pattern.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one byte of the line per word, req_tlast on its last byte.
//   rsp_* returns the edited line one byte per word; rsp_tlast marks the
//   final byte emitted for the line (a line whose last byte completes a
//   match with an empty replacement gets no rsp_tlast).
//   csr_* writes pattern, pattern length, replacement and replacement
//   length; any write empties the window and restarts the search. Write
//   only while no words are in flight.
// Timing:
//   A byte is taken every cycle while the block emits at most one byte per
//   input byte and rsp_tready stays high; each word is registered in the
//   output row and shows on rsp in the next cycle. Bursts (the replacement,
//   or the window flush at the end of the line, up to max(REPLACE_MAX + 1,
//   PATTERN_MAX) bytes) hold req_tready low until the row drains to one word.
//   The output row of cells is the output register, so rsp_tready never
//   reaches req_tready combinationally.
// Reset:
//   Synchronous; clears the config registers, the window fill count and the
//   output row count. Window bytes are always written before they are compared.
//   A stalled receiver fills the output row and then stops the input.
// ----------------------------------------------------------------------------
module stream_replace_first_match #(
   parameter int PATTERN_MAX = 8,
   parameter int REPLACE_MAX = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] in_byte
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,   // [7:0] out_byte
   output logic                          rsp_tlast,
   input  logic                          csr_we,
   input  srfm_pkg::csr_addr_type        csr_addr,
   input  logic [srfm_pkg::REG_W-1:0]    csr_wdata
);
   import srfm_pkg::*;

   localparam int MAX_RES = (REPLACE_MAX + 1 > PATTERN_MAX) ? REPLACE_MAX + 1 : PATTERN_MAX;
   localparam int DEPTH   = MAX_RES + 1;
   localparam int OCC_W   = $clog2(DEPTH + 1);

   // configuration registers
   logic [REG_W-1:0] pattern_ff, pattern_in;
   logic [LEN_W-1:0] plen_raw_ff, plen_raw_in;
   logic [REG_W-1:0] repl_ff, repl_in;
   logic [LEN_W-1:0] rlen_raw_ff, rlen_raw_in;

   // line state
   logic [LEN_W-1:0] count_ff, count_in;
   logic             done_ff, done_in;
   logic [OCC_W-1:0] occ_ff, occ_in;

   logic             acc;
   logic             pop;
   logic [LEN_W-1:0] plen;
   logic [LEN_W-1:0] rlen;
   logic [LEN_W-1:0] cnt1;
   logic             full;
   logic             match;
   logic [LEN_W-1:0] step_n;
   logic [OCC_W-1:0] occ_base;

   win_ctrl_type      win_ctrl;
   logic [BYTE_W-1:0] cand     [PATTERN_MAX];
   logic [BYTE_W-1:0] nbr_cand [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] hit;

   logic [BYTE_W-1:0] repl_ext [MAX_RES];
   logic [BYTE_W-1:0] cand_ext [MAX_RES];
   out_word_type      list     [MAX_RES];

   out_word_type q_word  [DEPTH];
   out_word_type q_nbr   [DEPTH];
   out_word_type q_load  [DEPTH];
   q_ctrl_type   q_ctrl  [DEPTH];

   assign acc = req_tvalid && req_tready;
   assign pop = rsp_tvalid && rsp_tready;

   // clamp lengths to the supported maxima
   assign plen = (plen_raw_ff > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : plen_raw_ff;
   assign rlen = (rlen_raw_ff > LEN_W'(REPLACE_MAX)) ? LEN_W'(REPLACE_MAX) : rlen_raw_ff;

   // configuration writes
   always_comb begin
      pattern_in  = pattern_ff;
      plen_raw_in = plen_raw_ff;
      repl_in     = repl_ff;
      rlen_raw_in = rlen_raw_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_PATTERN_BYTES:  pattern_in  = csr_wdata;
            CSR_PATTERN_LENGTH: plen_raw_in = csr_wdata[LEN_W-1:0];
            CSR_REPLACE_BYTES:  repl_in     = csr_wdata;
            CSR_REPLACE_LENGTH: rlen_raw_in = csr_wdata[LEN_W-1:0];
         endcase
      end
   end

   // window cells
   assign win_ctrl.update = acc;
   assign win_ctrl.shift  = full && !match;
   assign win_ctrl.count  = count_ff;
   assign win_ctrl.plen   = plen;

   for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_win
      if (i + 1 < PATTERN_MAX) begin : g_nbr
         assign nbr_cand[i] = cand[i+1];
      end else begin : g_end
         assign nbr_cand[i] = '0;
      end

      srfm_win_cell #(
         .CELL_IDX (i)
      ) u_cell (
         .clock    (clock),
         .ctrl     (win_ctrl),
         .in_byte  (req_tdata),
         .nbr_cand (nbr_cand[i]),
         .pat_byte (pattern_ff[BYTE_W*i +: BYTE_W]),
         .cand     (cand[i]),
         .hit      (hit[i])
      );
   end

   assign cnt1  = count_ff + LEN_W'(1);
   assign full  = (plen != '0) && (cnt1 == plen);
   assign match = full && (&hit);

   // widen replacement and window bytes to the result list length
   for (genvar k = 0; k < MAX_RES; k++) begin : g_ext
      if (k < REPLACE_MAX) begin : g_r
         assign repl_ext[k] = repl_ff[BYTE_W*k +: BYTE_W];
      end else begin : g_rz
         assign repl_ext[k] = '0;
      end
      if (k < PATTERN_MAX) begin : g_c
         assign cand_ext[k] = cand[k];
      end else begin : g_cz
         assign cand_ext[k] = '0;
      end
   end

   // result count of this step
   always_comb begin
      priority if (done_ff) begin
         step_n = LEN_W'(1);
      end else if (plen == '0) begin
         step_n = rlen + LEN_W'(1);
      end else if (match) begin
         step_n = rlen;
      end else if (req_tlast) begin
         step_n = cnt1;
      end else begin
         step_n = full ? LEN_W'(1) : '0;
      end
   end

   // result words of this step; flush follows on the last byte
   always_comb begin
      for (int k = 0; k < MAX_RES; k++) begin
         priority if (done_ff) begin
            list[k].data = req_tdata;
         end else if (plen == '0) begin
            list[k].data = (LEN_W'(k) < rlen) ? repl_ext[k] : req_tdata;
         end else if (match) begin
            list[k].data = repl_ext[k];
         end else begin
            list[k].data = cand_ext[k];
         end
         list[k].last = req_tlast && (LEN_W'(k) == step_n - LEN_W'(1));
      end
   end

   // next line state
   always_comb begin
      count_in = count_ff;
      done_in  = done_ff;
      priority if (csr_we) begin
         count_in = '0;
         done_in  = 1'b0;
      end else if (acc) begin
         priority if (req_tlast || done_ff || plen == '0 || match) begin
            count_in = '0;
         end else if (!full) begin
            count_in = cnt1;
         end else begin
            count_in = count_ff;
         end
         done_in = !req_tlast && (done_ff || plen == '0 || match);
      end else begin
         done_in = done_ff;
      end
   end

   // output row: drop the head on a take, append the step's words behind
   assign occ_base   = occ_ff - OCC_W'(pop);
   assign occ_in     = occ_base + (acc ? OCC_W'(step_n) : '0);
   assign req_tready = (occ_ff <= OCC_W'(1));

   for (genvar j = 0; j < DEPTH; j++) begin : g_out
      out_word_type lw0, lw1;

      if (j + 1 < DEPTH) begin : g_nbr
         assign q_nbr[j] = q_word[j+1];
      end else begin : g_end
         assign q_nbr[j] = '0;
      end

      if (j < MAX_RES) begin : g_l0
         assign lw0 = list[j];
      end else begin : g_l0z
         assign lw0 = '0;
      end
      if (j >= 1 && j - 1 < MAX_RES) begin : g_l1
         assign lw1 = list[j-1];
      end else begin : g_l1z
         assign lw1 = '0;
      end

      assign q_load[j]       = occ_base[0] ? lw1 : lw0;
      assign q_ctrl[j].shift = pop;
      assign q_ctrl[j].load  = acc && (OCC_W'(j) >= occ_base) &&
                               (OCC_W'(j) < occ_base + OCC_W'(step_n));

      srfm_out_cell u_cell (
         .clock     (clock),
         .ctrl      (q_ctrl[j]),
         .nbr_word  (q_nbr[j]),
         .load_word (q_load[j]),
         .word      (q_word[j])
      );
   end

   assign rsp_tvalid = (occ_ff != '0);
   assign rsp_tdata  = q_word[0].data;
   assign rsp_tlast  = q_word[0].last;

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff  <= '0;
         plen_raw_ff <= '0;
         repl_ff     <= '0;
         rlen_raw_ff <= '0;
         count_ff    <= '0;
         done_ff     <= 1'b0;
         occ_ff      <= '0;
      end else begin
         pattern_ff  <= pattern_in;
         plen_raw_ff <= plen_raw_in;
         repl_ff     <= repl_in;
         rlen_raw_ff <= rlen_raw_in;
         count_ff    <= count_in;
         done_ff     <= done_in;
         occ_ff      <= occ_in;
      end
   end

   // output row never overfills
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(DEPTH))
      else $error("output row overfilled");

   // window fill stays below the pattern length
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) || (count_ff < plen))
      else $error("window fill reached pattern length");

   // after the replacement the window stays empty
   a_done_empty: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (count_ff == '0))
      else $error("window not empty after replacement");

   // the last byte of a line restarts the search
   a_line_end: assert property (@(posedge clock) disable iff (reset)
      (acc && req_tlast) |=> (!done_ff && count_ff == '0))
      else $error("line state not cleared at end of line");

endmodule

### tb/tb_stream_replace_first_match.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stream_replace_first_match
// Self-checking bench for the streaming first-match replace block.
// A directed table covers the reset state, zero and all-ones bytes, clamped
// lengths, the empty pattern, register writes that drop a held window and a
// line that ends on a match with an empty replacement. Random lines follow;
// they are built from whole and partial copies of the pattern mixed with
// noise. They run under several register settings and under idle and stall
// phases on both sides, including one long receiver hold-off. Each output word
// is checked against a typed table word or a behavioural predictor of the edit.
// ----------------------------------------------------------------------------
module tb_stream_replace_first_match;
   import srfm_pkg::*;

   localparam int PAT_MAX       = 8;
   localparam int REP_MAX       = 8;
   localparam int SETTLE_CYCLES = 16;    // longest burst plus margin
   localparam int END_CYCLES    = 20;
   localparam int QUIET_LIMIT   = 2000;  // cycles with no handshake or register write
   localparam int HOLD_CYCLES   = 80;
   localparam int WORDS_PER_SET = 34;
   localparam int DIR_ROWS      = 31;

   typedef enum bit {ROW_WORD, ROW_CSR} row_kind_type;

   // one row of the directed table; addr is unused on word rows
   typedef struct packed {
      row_kind_type kind;
      csr_addr_type addr;
      logic [63:0]  value;
      bit           last;
      bit           typed;
      out_word_type want;
   } dir_row_type;

   localparam dir_row_type DIR_TAB [DIR_ROWS] = '{
      // reset state: empty pattern, empty replacement, so copy the line
      '{ROW_WORD, CSR_PATTERN_BYTES,  64'h00,       1'b0, 1'b1, '{8'h00, 1'b0}},
      '{ROW_WORD, CSR_PATTERN_BYTES,  64'hFF,       1'b1, 1'b1, '{8'hFF, 1'b1}},
      // pattern "ab", replacement "XYZ"
      '{ROW_CSR,  CSR_PATTERN_BYTES,  64'h6261,     1'b0, 1'b0, '0},
      '{ROW_CSR,  CSR_PATTERN_LENGTH, 64'h2,        1'b0, 1'b0, '0},
      '{ROW_CSR,  CSR_REPLACE_BYTES,  64'h5A5958,   1'b0, 1'b0, '0},
      '{ROW_CSR,  CSR_REPLACE_LENGTH, 64'h3,        1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_PATTERN_BYTES,  64'h78,       1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_PATTERN_BYTES,  64'h61,       1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_PATTERN_BYTES,  64'h62,       1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_PATTERN_BYTES,  64'h61,       1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_PATTERN_BYTES,  64'h62,       1'b1, 1'b0, '0},
      // near miss, flushed at the end of the line
      '{ROW_WORD, CSR_PATTERN_BYTES,  64'h61,       1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_PATTERN_BYTES,  64'h61,       1'b1, 1'b0, '0},
      // held byte dropped by a register write, then match with empty replacement
      '{ROW_WORD, CSR_PATTERN_BYTES,  64'h61,       1'b0, 1'b0, '0},
      '{ROW_CSR,  CSR_REPLACE_LENGTH, 64'h0,        1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_PATTERN_BYTES,  64'h61,       1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_PATTERN_BYTES,  64'h62,       1'b1, 1'b0, '0},
      // zero-byte pattern and all-ones replacement, both lengths clamped
      '{ROW_CSR,  CSR_PATTERN_BYTES,  64'h0,        1'b0, 1'b0, '0},
      '{ROW_CSR,  CSR_PATTERN_LENGTH, 64'hF,        1'b0, 1'b0, '0},
      '{ROW_CSR,  CSR_REPLACE_BYTES,  {64{1'b1}},   1'b0, 1'b0, '0},
      '{ROW_CSR,  CSR_REPLACE_LENGTH, 64'hF,        1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_PATTERN_BYTES,  64'h00,       1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_PATTERN_BYTES,  64'h00,       1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_PATTERN_BYTES,  64'h00,       1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_PATTERN_BYTES,  64'h00,       1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_PATTERN_BYTES,  64'h00,       1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_PATTERN_BYTES,  64'h00,       1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_PATTERN_BYTES,  64'h00,       1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_PATTERN_BYTES,  64'h00,       1'b1, 1'b0, '0},
      // empty pattern: full replacement before the byte, the longest burst
      '{ROW_CSR,  CSR_PATTERN_LENGTH, 64'h0,        1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_PATTERN_BYTES,  64'h7F,       1'b1, 1'b0, '0}
   };

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [7:0]         req_tdata  = 8'h00;   // [7:0] in_byte
   logic               req_tlast  = 1'b0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [7:0]         rsp_tdata;            // [7:0] out_byte
   logic               rsp_tlast;
   logic               csr_we     = 1'b0;
   csr_addr_type       csr_addr   = CSR_PATTERN_BYTES;
   logic [REG_W-1:0]   csr_wdata  = '0;

   // predictor state and register copies
   logic [7:0]         win_b [PAT_MAX];
   int                 win_n     = 0;
   bit                 swap_done = 1'b0;
   logic [63:0]        cfg_pat   = '0;
   logic [3:0]         cfg_plen  = '0;
   logic [63:0]        cfg_rep   = '0;
   logic [3:0]         cfg_rlen  = '0;

   out_word_type       step_q   [$];   // words caused by one input byte
   out_word_type       edited_q [$];   // words still awaited from the block

   int                 req_idle_pct  = 0;
   int                 rsp_stall_pct = 0;
   logic               hold_rsp      = 1'b0;
   bit                 csr_drain     = 1'b0;
   int                 quiet_cycles  = 0;
   int                 n_errors = 0;
   int                 n_in     = 0;
   int                 n_out    = 0;
   int                 n_lines  = 0;
   int                 n_csr    = 0;

   stream_replace_first_match u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   task report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
      $display("error at %0t: %s got %h want %h", $realtime, what, got, want);
      n_errors++;
   endtask

   function automatic void emit(input logic [7:0] b);
      step_q.push_back(out_word_type'{data: b, last: 1'b0});
   endfunction

   // work out the words that one input byte causes, and advance the window
   task automatic edit_byte(input logic [7:0] b, input bit last);
      int plen, rlen, i;
      bit hit;
      plen = (cfg_plen > PAT_MAX) ? PAT_MAX : int'(cfg_plen);
      rlen = (cfg_rlen > REP_MAX) ? REP_MAX : int'(cfg_rlen);
      step_q.delete();
      if (swap_done) begin
         emit(b);
      end else if (plen == 0) begin
         for (i = 0; i < rlen; i++) emit(cfg_rep[8*i +: 8]);
         emit(b);
         swap_done = 1'b1;
      end else begin
         if (win_n >= plen) win_n = 0;
         win_b[win_n] = b;
         win_n++;
         if (win_n == plen) begin
            hit = 1'b1;
            for (i = 0; i < plen; i++)
               if (win_b[i] != cfg_pat[8*i +: 8]) hit = 1'b0;
            if (hit) begin
               for (i = 0; i < rlen; i++) emit(cfg_rep[8*i +: 8]);
               win_n     = 0;
               swap_done = 1'b1;
            end else begin
               // window full without a match: release the oldest byte
               emit(win_b[0]);
               for (i = 1; i < win_n; i++) win_b[i-1] = win_b[i];
               win_n--;
            end
         end
      end
      // end of line: flush the window and restart the search
      if (last) begin
         for (i = 0; i < win_n; i++) emit(win_b[i]);
         win_n     = 0;
         swap_done = 1'b0;
         if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
      end
   endtask

   // offer one byte and wait for it to be taken
   task automatic drive_word(input logic [7:0] b, input bit last,
                             input bit typed, input out_word_type typed_w);
      int i;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      edit_byte(b, last);
      if (typed) edited_q.push_back(typed_w);
      else for (i = 0; i < step_q.size(); i++) edited_q.push_back(step_q[i]);
      csr_drain = 1'b1;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      n_in++;
      if (last) n_lines++;
   endtask

   // write one register once the block has gone quiet
   task automatic write_csr(input csr_addr_type addr, input logic [63:0] value);
      req_tvalid <= 1'b0;
      if (csr_drain) begin
         while (edited_q.size() != 0) @(posedge clock);
         repeat (SETTLE_CYCLES) @(posedge clock);
         csr_drain = 1'b0;
      end
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      unique case (addr)
         CSR_PATTERN_BYTES:  cfg_pat  = value;
         CSR_PATTERN_LENGTH: cfg_plen = value[3:0];
         CSR_REPLACE_BYTES:  cfg_rep  = value;
         CSR_REPLACE_LENGTH: cfg_rlen = value[3:0];
      endcase
      win_n     = 0;
      swap_done = 1'b0;
      n_csr++;
   endtask

   // mostly short lengths, with the empty, full and clamped extremes
   function automatic logic [63:0] pick_len();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 64'd0;
      if (r == 1) return 64'd8;
      if (r == 2) return 64'($urandom_range(9, 15));
      return 64'($urandom_range(1, 4));
   endfunction

   task automatic pick_settings();
      logic [63:0] pat;
      int i;
      if ($urandom_range(0, 3) == 0) begin
         pat = {$urandom, $urandom};
      end else begin
         // small alphabet, so partial and overlapping matches are common
         for (i = 0; i < 8; i++) pat[8*i +: 8] = 8'h61 + 8'($urandom_range(0, 3));
      end
      write_csr(CSR_PATTERN_BYTES, pat);
      write_csr(CSR_PATTERN_LENGTH, pick_len());
      write_csr(CSR_REPLACE_BYTES, {$urandom, $urandom});
      write_csr(CSR_REPLACE_LENGTH, pick_len());
   endtask

   // build a line from pattern copies, prefixes, pattern bytes and noise
   task automatic send_line();
      logic [7:0] text [$];
      int len, plen, k, cut, i;
      len  = $urandom_range(1, 14);
      plen = (cfg_plen > PAT_MAX) ? PAT_MAX : int'(cfg_plen);
      while (text.size() < len) begin
         k = $urandom_range(0, 9);
         if (plen != 0 && k < 3) begin
            for (i = 0; i < plen; i++) text.push_back(cfg_pat[8*i +: 8]);
         end else if (plen != 0 && k < 5) begin
            cut = $urandom_range(1, plen);
            for (i = 0; i < cut; i++) text.push_back(cfg_pat[8*i +: 8]);
         end else if (plen != 0 && k < 8) begin
            text.push_back(cfg_pat[8*$urandom_range(0, plen-1) +: 8]);
         end else begin
            text.push_back(8'($urandom_range(0, 255)));
         end
      end
      for (i = 0; i < text.size(); i++)
         drive_word(text[i], i == text.size() - 1, 1'b0, '0);
   endtask

   task automatic send_text(input int words);
      int mark;
      mark = n_in;
      while (n_in - mark < words) send_line();
   endtask

   // receiver: stall at random, check each word against the oldest expectation
   always @(posedge clock) begin : rsp_side
      out_word_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !hold_rsp && ($urandom_range(0, 99) >= rsp_stall_pct);
         if (rsp_tvalid && rsp_tready) begin
            n_out++;
            if (edited_q.size() == 0) begin
               report_mismatch("word with nothing expected", rsp_tdata, 8'h00);
            end else begin
               want = edited_q.pop_front();
               if (rsp_tdata !== want.data) report_mismatch("out_byte", rsp_tdata, want.data);
               if (rsp_tlast !== want.last)
                  report_mismatch("out_last", 8'(rsp_tlast), 8'(want.last));
            end
         end
      end
   end

   // watchdog: give up after a long stretch with no handshake or register write
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      int r, ph, s;
      for (r = 0; r < PAT_MAX; r++) win_b[r] = 8'h00;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (r = 0; r < DIR_ROWS; r++) begin
         if (DIR_TAB[r].kind == ROW_CSR)
            write_csr(DIR_TAB[r].addr, DIR_TAB[r].value);
         else
            drive_word(DIR_TAB[r].value[7:0], DIR_TAB[r].last, DIR_TAB[r].typed,
                       DIR_TAB[r].want);
      end

      // random lines: no idling, sender idle, receiver stall, both
      for (ph = 0; ph < 4; ph++) begin
         case (ph)
            0:       begin req_idle_pct = 0;  rsp_stall_pct <= 0;  end
            1:       begin req_idle_pct = 54; rsp_stall_pct <= 0;  end
            2:       begin req_idle_pct = 0;  rsp_stall_pct <= 54; end
            default: begin req_idle_pct = 14; rsp_stall_pct <= 14; end
         endcase
         for (s = 0; s < 2; s++) begin
            pick_settings();
            if (ph == 0 && s == 1) begin
               // hold the receiver off so the output row fills and stalls the input
               fork
                  begin
                     hold_rsp <= 1'b1;
                     repeat (HOLD_CYCLES) @(posedge clock);
                     hold_rsp <= 1'b0;
                  end
                  send_text(WORDS_PER_SET);
               join
            end else begin
               send_text(WORDS_PER_SET);
            end
         end
      end

      // drain and settle
      req_tvalid <= 1'b0;
      while (edited_q.size() != 0) @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);
      if (edited_q.size() != 0)
         report_mismatch("words never received", 8'(edited_q.size()), 8'h00);

      $display("Sent %0d bytes in %0d lines under %0d register writes, received %0d bytes,",
               n_in, n_lines, n_csr, n_out);
      $display("with idle and stall phases on both sides and one long output hold-off.");
      if (n_errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
